// File: sv/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg: shared types and constants for the matrix-vector multiplier
// Widths, register indexes, the token that walks the cell chain and the
// dimension clamp used by the front end.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // largest matrix dimension, one chain cell per vector element
    localparam int MAX_DIM = 64;
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W   = IDX_W + 1;

    // fixed field widths
    localparam int VALUE_W  = 32;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int ROW_W    = 6;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_W   = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

    localparam logic [CFG_W-1:0] DIM_RESET = 7'd4;

    // input command codes
    localparam logic CMD_VECTOR = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    // token handed from cell to cell
    typedef struct packed {
        logic                      valid;
        logic                      load;
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] xval;
        logic                      first;
        logic                      emit;
        logic [ROW_W-1:0]          row;
        logic                      last;
    } mvm_token_t;

    // register value to effective dimension: zero acts as one, clamp at MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0)
            d = DIM_W'(1);
        else if (32'(r) > MAX_DIM)
            d = DIM_W'(MAX_DIM);
        else
            d = DIM_W'(r);
        return d;
    endfunction

endpackage

// File: sv/mvm_in_if.sv
// ----------------------------------------------------------------------------
// mvm_in_if: input channel
// Valid/ready channel carrying one vector or matrix element per transfer.
// ----------------------------------------------------------------------------
interface mvm_in_if import mvm_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);

endinterface

// File: sv/mvm_out_if.sv
// ----------------------------------------------------------------------------
// mvm_out_if: result channel
// Valid/ready channel carrying one finished row sum per transfer.
// ----------------------------------------------------------------------------
interface mvm_out_if import mvm_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] row_sum;
    logic [ROW_W-1:0]          row_number;
    logic                      last;

    modport source (output valid, output row_sum, output row_number, output last,
                    input ready);
    modport sink   (input valid, input row_sum, input row_number, input last,
                    output ready);

endinterface

// File: sv/mvm_ctrl.sv
// ----------------------------------------------------------------------------
// mvm_ctrl: front end
// Holds the configuration registers and the load, column and row positions,
// and turns each accepted element into a token for the cell chain.
// ----------------------------------------------------------------------------
module mvm_ctrl import mvm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic                  in_cmd,
    input  logic [VALUE_W-1:0]    in_value,
    output mvm_token_t            tok
);

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    logic [IDX_W-1:0] load_pos_reg, load_pos_next;
    logic [IDX_W-1:0] col_pos_reg, col_pos_next;
    logic [IDX_W-1:0] row_pos_reg, row_pos_next;

    logic [DIM_W-1:0] rows_eff;
    logic [DIM_W-1:0] cols_eff;
    logic [IDX_W-1:0] load_idx;
    logic [IDX_W-1:0] col_idx;
    logic [IDX_W-1:0] row_idx;
    logic [DIM_W-1:0] load_inc;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             accept;
    logic             row_done;
    logic             final_row;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS: rows_reg <= cfg_data;
                REG_COLS: cols_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // positions wrapped into the current dimensions
    always_comb
    begin
        rows_eff  = eff_dim(rows_reg);
        cols_eff  = eff_dim(cols_reg);
        accept    = in_valid && adv;
        load_idx  = ({1'b0, load_pos_reg} >= cols_eff) ? '0 : load_pos_reg;
        col_idx   = ({1'b0, col_pos_reg} >= cols_eff) ? '0 : col_pos_reg;
        row_idx   = ({1'b0, row_pos_reg} >= rows_eff) ? '0 : row_pos_reg;
        load_inc  = {1'b0, load_idx} + DIM_W'(1);
        col_inc   = {1'b0, col_idx} + DIM_W'(1);
        row_inc   = {1'b0, row_idx} + DIM_W'(1);
        row_done  = col_inc >= cols_eff;
        final_row = row_inc >= rows_eff;
    end

    // next positions
    always_comb
    begin
        load_pos_next = load_pos_reg;
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        if (accept)
        begin
            if (in_cmd == CMD_VECTOR)
            begin
                load_pos_next = (load_inc >= cols_eff) ? '0 : load_inc[IDX_W-1:0];
                col_pos_next  = '0;
                row_pos_next  = '0;
            end
            else
            begin
                load_pos_next = '0;
                if (row_done)
                begin
                    col_pos_next = '0;
                    row_pos_next = final_row ? '0 : row_inc[IDX_W-1:0];
                end
                else
                begin
                    col_pos_next = col_inc[IDX_W-1:0];
                    row_pos_next = row_idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
        end
        else
        begin
            load_pos_reg <= load_pos_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
        end
    end

    // token for the head of the chain
    always_comb
    begin
        tok.valid = accept;
        tok.load  = (in_cmd == CMD_VECTOR);
        tok.idx   = (in_cmd == CMD_VECTOR) ? load_idx : col_idx;
        tok.value = $signed(in_value);
        tok.xval  = '0;
        tok.first = (col_idx == '0);
        tok.emit  = row_done;
        tok.row   = ROW_W'(row_idx);
        tok.last  = final_row;
    end

    // a completed row restarts at column zero
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_cmd == CMD_MATRIX) && row_done |=> col_pos_reg == '0)
        else $error("column position not cleared after a row");

    // a vector transfer restarts the matrix position
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_cmd == CMD_VECTOR) |=> (col_pos_reg == '0) && (row_pos_reg == '0))
        else $error("matrix position not cleared by a vector load");

endmodule

// File: sv/mvm_cell.sv
// ----------------------------------------------------------------------------
// mvm_cell: one vector element cell
// Holds one element of x. A load token addressed to this cell writes it; a
// matrix token addressed to it picks it up. Every token moves on each cycle that adv is high.
// ----------------------------------------------------------------------------
module mvm_cell import mvm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [IDX_W-1:0] cell_index,
    input  mvm_token_t       tok_in,
    output mvm_token_t       tok_out
);

    logic signed [VALUE_W-1:0] x_reg;
    logic                      valid_reg;
    mvm_token_t                tok_reg, tok_next;
    logic                      hit;

    assign hit = tok_in.valid && (tok_in.idx == cell_index);

    // stored element
    always_ff @(posedge clk)
    begin
        if (adv && hit && tok_in.load)
            x_reg <= tok_in.value;
    end

    // token valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= tok_in.valid;
    end

    // token payload, element picked up on a hit
    always_comb
    begin
        tok_next = tok_in;
        if (hit && !tok_in.load)
            tok_next.xval = x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

// File: sv/mvm_mac.sv
// ----------------------------------------------------------------------------
// mvm_mac: multiply, accumulate and row output
// Multiplies each matrix element by its vector element, adds the product
// into a saturating 64-bit accumulator and turns a finished row into Q16.16.
// ----------------------------------------------------------------------------
module mvm_mac import mvm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mvm_token_t                tok,
    output logic                      adv,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] row_sum,
    output logic [ROW_W-1:0]          row_number,
    output logic                      last
);

    localparam int SH_W = PROD_W - FRAC_W;

    // multiply stage
    logic                     mul_valid_reg;
    logic                     mul_first_reg;
    logic                     mul_emit_reg;
    logic [ROW_W-1:0]         mul_row_reg;
    logic                     mul_last_reg;
    logic signed [PROD_W-1:0] mul_prod_reg;

    // accumulate stage
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic                     fin_valid_reg;
    logic [ROW_W-1:0]         fin_row_reg;
    logic                     fin_last_reg;

    // output stage
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] row_sum_reg, row_sum_next;
    logic [ROW_W-1:0]          row_number_reg;
    logic                      last_reg;

    logic signed [PROD_W-1:0] acc_base;
    logic signed [PROD_W:0]   acc_wide;
    logic signed [SH_W-1:0]   acc_shift;

    // stall only when a finished row meets a full output register
    assign adv = !(fin_valid_reg && out_valid_reg && !out_ready);

    // product of element and vector entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (adv)
            mul_valid_reg <= tok.valid && !tok.load;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_first_reg <= tok.first;
            mul_emit_reg  <= tok.emit;
            mul_row_reg   <= tok.row;
            mul_last_reg  <= tok.last;
            mul_prod_reg  <= tok.value * tok.xval;
        end
    end

    // saturating accumulate
    always_comb
    begin
        acc_base = mul_first_reg ? '0 : acc_reg;
        acc_wide = {acc_base[PROD_W-1], acc_base} + {mul_prod_reg[PROD_W-1], mul_prod_reg};
        if (acc_wide[PROD_W] != acc_wide[PROD_W-1])
            acc_next = acc_wide[PROD_W] ? {1'b1, {(PROD_W-1){1'b0}}}
                                        : {1'b0, {(PROD_W-1){1'b1}}};
        else
            acc_next = acc_wide[PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (mul_valid_reg)
                acc_reg <= acc_next;
            fin_valid_reg <= mul_valid_reg && mul_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_row_reg  <= mul_row_reg;
            fin_last_reg <= mul_last_reg;
        end
    end

    // floor shift to Q16.16 and saturate to 32 bits
    always_comb
    begin
        acc_shift = acc_reg[PROD_W-1:FRAC_W];
        if (acc_shift[SH_W-1:VALUE_W-1] == '0 || acc_shift[SH_W-1:VALUE_W-1] == '1)
            row_sum_next = acc_shift[VALUE_W-1:0];
        else
            row_sum_next = acc_shift[SH_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                             : {1'b0, {(VALUE_W-1){1'b1}}};
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (adv && fin_valid_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && fin_valid_reg)
        begin
            row_sum_reg    <= row_sum_next;
            row_number_reg <= fin_row_reg;
            last_reg       <= fin_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_sum    = row_sum_reg;
    assign row_number = row_number_reg;
    assign last       = last_reg;

    // a finished row waiting on a stall is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !adv |=> fin_valid_reg)
        else $error("finished row lost during a stall");

    // the pipeline stalls only against a full, untaken output register
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> out_valid_reg && !out_ready && fin_valid_reg)
        else $error("pipeline stalled without output back pressure");

    // a row leaving the accumulator reaches the output in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && fin_valid_reg |=> out_valid_reg)
        else $error("finished row not presented at the output");

endmodule

// File: sv/matrix_vector_multiply_top.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_top: streaming y = A x in signed Q16.16
// Vector elements load into a chain of cells; matrix elements walk the chain,
// pick up their vector entry, then go through a multiplier and a saturating
// accumulator. One row sum leaves per completed row.
//
//   channel   direction  transfer contents
//   in_ch     in         cmd, value (vector or matrix element)
//   out_ch    out        row_sum, row_number, last (one finished row)
//   cfg_*     in         register write: REG_ROWS, REG_COLS
//
// One element is accepted every cycle while the input is not stalled. The
// last element of a row passes one register per chain cell, starting with
// the accepting edge, then the multiply, accumulate and output registers,
// before its row sum is presented.
// Reset clears positions, the accumulator and all token valids; the vector
// cells are not cleared and must be loaded before use.
// The input stalls only when a finished row reaches a full output register
// that is not being taken.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top import mvm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    mvm_in_if.sink               in_ch,
    mvm_out_if.source            out_ch
);

    logic       adv;
    mvm_token_t chain_tok [MAX_DIM+1];

    assign in_ch.ready = adv;

    // position control and token build
    mvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .adv       (adv),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_value  (in_ch.value),
        .tok       (chain_tok[0])
    );

    // chain of vector element cells
    for (genvar i = 0; i < MAX_DIM; i++)
    begin : g_cell
        mvm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .cell_index (IDX_W'(i)),
            .tok_in     (chain_tok[i]),
            .tok_out    (chain_tok[i+1])
        );
    end

    // multiply, accumulate and output
    mvm_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok        (chain_tok[MAX_DIM]),
        .adv        (adv),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .row_sum    (out_ch.row_sum),
        .row_number (out_ch.row_number),
        .last       (out_ch.last)
    );

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming matrix-vector multiplier
// Loads vectors and streams matrices through the input channel with random
// gaps, while a scoreboard predicts each row sum in signed Q16.16. Every
// row result taken from the output channel, under random back-pressure, is
// checked field by field. Directed tests cover value extremes, saturation,
// dimension clamping and positions left out of range by a dimension change.
// A random phase then sweeps many dimension settings.
// ----------------------------------------------------------------------------
module tb_top;
    import mvm_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 950;
    localparam int SETTLE_WAIT  = MAX_DIM + 8;

    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
    localparam longint SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SUM_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] row_sum;
        logic [ROW_W-1:0]          row_number;
        logic                      last;
    } row_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    mvm_in_if  in_ch ();
    mvm_out_if out_ch ();

    matrix_vector_multiply_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // scoreboard state: stored vector, positions, accumulator, registers
    logic signed [VALUE_W-1:0] x_store [MAX_DIM];
    bit                        x_loaded [MAX_DIM];
    int                        x_fill;
    int                        col_at;
    int                        row_at;
    longint                    row_acc;
    logic [CFG_W-1:0]          rows_cfg;
    logic [CFG_W-1:0]          cols_cfg;

    row_result_t pending_rows [$];

    int mismatches;
    int quiet_cycles;
    bit no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // register value to dimension: zero means one, clamp at the array size
    function automatic int dim_of(input logic [CFG_W-1:0] r);
        if (r == '0)
            return 1;
        if (int'(r) > MAX_DIM)
            return MAX_DIM;
        return int'(r);
    endfunction

    // 64-bit add that sticks at the rails
    function automatic longint add_clamped(input longint a, input longint b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63])
            return s[64] ? ACC_MIN : ACC_MAX;
        return s[63:0];
    endfunction

    // Q32.32 accumulator to Q16.16: floor shift, then clamp to 32 bits
    function automatic logic signed [VALUE_W-1:0] round_row(input longint a);
        longint q;
        q = a >>> FRAC_W;
        if (q > SUM_MAX)
            q = SUM_MAX;
        else if (q < SUM_MIN)
            q = SUM_MIN;
        return q[VALUE_W-1:0];
    endfunction

    // advance the scoreboard by one accepted element
    function automatic void predict_element(input logic c,
                                            input logic signed [VALUE_W-1:0] v);
        int          cols;
        int          rows;
        int          slot;
        longint      prod;
        row_result_t res;
        cols = dim_of(cols_cfg);
        rows = dim_of(rows_cfg);
        if (c == CMD_VECTOR)
        begin
            slot = (x_fill >= cols) ? 0 : x_fill;
            x_store[slot]  = v;
            x_loaded[slot] = 1'b1;
            slot++;
            x_fill  = (slot >= cols) ? 0 : slot;
            col_at  = 0;
            row_at  = 0;
            row_acc = 0;
        end
        else
        begin
            x_fill = 0;
            if (col_at >= cols)
            begin
                col_at  = 0;
                row_acc = 0;
            end
            if (row_at >= rows)
                row_at = 0;
            prod    = longint'(v) * longint'(x_store[col_at]);
            row_acc = add_clamped(row_acc, prod);
            col_at++;
            if (col_at >= cols)
            begin
                res.row_sum    = round_row(row_acc);
                res.row_number = ROW_W'(row_at);
                res.last       = (row_at + 1 >= rows);
                pending_rows.push_back(res);
                row_acc = 0;
                col_at  = 0;
                row_at++;
                if (row_at >= rows)
                    row_at = 0;
            end
        end
    endfunction

    // true when the next matrix element reads a loaded vector entry
    function automatic bit next_column_loaded();
        int cols;
        cols = dim_of(cols_cfg);
        return x_loaded[(col_at >= cols) ? 0 : col_at];
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // element values: rails, small Q16.16 numbers, or any pattern
    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sh0000_0000;
                    3: v = 32'shFFFF_FFFF;
                    default: v = 32'sh0001_0000;
                endcase
            end
            1, 2, 3: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // one input transfer, after a random gap
    task automatic send_element(input logic c, input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= c;
        in_ch.value <= v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_element(c, v);
    endtask

    // matrix element, or a vector load where the column was never loaded
    task automatic send_matrix_element(input logic signed [VALUE_W-1:0] v);
        if (next_column_loaded())
            send_element(CMD_MATRIX, v);
        else
            send_element(CMD_VECTOR, v);
    endtask

    // drain all rows, then let loads still walking the chain land
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // write both dimension registers on back-to-back edges
    task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        rows_cfg = rows;
        cfg_index <= REG_COLS;
        cfg_data  <= cols;
        @(posedge clk);
        cols_cfg = cols;
        cfg_we <= 1'b0;
    endtask

    // reset dimensions (4 x 4) with value extremes
    task automatic test_reset_dims();
        send_element(CMD_VECTOR, 32'sh7FFF_FFFF);
        send_element(CMD_VECTOR, 32'sh8000_0000);
        send_element(CMD_VECTOR, 32'sh0001_0000);
        send_element(CMD_VECTOR, 32'shFFFF_FFFF);
        send_element(CMD_MATRIX, 32'sh8000_0000);
        send_element(CMD_MATRIX, 32'sh8000_0000);
        send_element(CMD_MATRIX, 32'sh7FFF_FFFF);
        send_element(CMD_MATRIX, 32'sh0000_0001);
    endtask

    // accumulator pinned at both rails, then the row sum clamped
    task automatic test_saturation();
        settle_block();
        set_dims(7'd2, 7'd3);
        repeat (3) send_element(CMD_VECTOR, 32'sh8000_0000);
        repeat (3) send_element(CMD_MATRIX, 32'sh8000_0000);
        repeat (3) send_element(CMD_MATRIX, 32'sh7FFF_FFFF);
    endtask

    // zero registers act as one; load wraps; floor rounding of negatives
    task automatic test_dim_clamp();
        settle_block();
        set_dims(7'd0, 7'd0);
        send_element(CMD_VECTOR, 32'sh0001_0000);
        send_element(CMD_VECTOR, 32'shFFFF_FFFF);
        send_element(CMD_MATRIX, 32'sh0001_8000);
        send_element(CMD_MATRIX, 32'sh0000_0001);
    endtask

    // column, row and load positions left beyond a shrunk dimension
    task automatic test_position_rescale();
        settle_block();
        set_dims(7'd3, 7'd3);
        send_element(CMD_MATRIX, 32'sh0002_0000);
        send_element(CMD_MATRIX, 32'shFFFE_0000);
        send_element(CMD_MATRIX, 32'sh0000_4000);
        send_element(CMD_MATRIX, 32'sh0001_0000);
        send_element(CMD_MATRIX, 32'sh0003_0000);
        // partial row abandoned by fewer columns
        settle_block();
        set_dims(7'd3, 7'd2);
        send_element(CMD_MATRIX, 32'sh0000_8000);
        send_element(CMD_MATRIX, 32'shFFFF_8000);
        // row index past the new row count
        settle_block();
        set_dims(7'd1, 7'd2);
        send_element(CMD_MATRIX, 32'sh0001_0000);
        send_element(CMD_MATRIX, 32'sh0001_0000);
        // load position past the new column count
        send_element(CMD_VECTOR, 32'sh0004_0000);
        settle_block();
        set_dims(7'd1, 7'd1);
        send_element(CMD_VECTOR, 32'sh0000_2000);
        send_element(CMD_MATRIX, 32'sh0005_0000);
    endtask

    function automatic logic [CFG_W-1:0] extreme_dim();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return CFG_W'(MAX_DIM);
            2: return '1;
            default: return CFG_W'($urandom_range(MAX_DIM + 1, 126));
        endcase
    endfunction

    // random dimensions, vectors and products with some broken sequences
    task automatic test_random_products();
        int items;
        int products;
        int span;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            settle_block();
            case ($urandom_range(0, 15))
                0:
                begin
                    rows = extreme_dim();
                    cols = CFG_W'($urandom_range(1, 2));
                end
                1:
                begin
                    rows = CFG_W'($urandom_range(1, 2));
                    cols = extreme_dim();
                end
                default:
                begin
                    rows = CFG_W'($urandom_range(1, 8));
                    cols = CFG_W'($urandom_range(1, 8));
                end
            endcase
            set_dims(rows, cols);
            no_idle = ($urandom_range(0, 3) == 0);
            // fresh vector most of the time, else reuse what is stored
            if ($urandom_range(0, 4) != 0)
            begin
                for (int i = 0; i < dim_of(cols); i++)
                begin
                    send_element(CMD_VECTOR, rand_value());
                    items++;
                end
            end
            span     = dim_of(rows) * dim_of(cols);
            products = (span > 64) ? 1 : $urandom_range(1, 3);
            for (int p = 0; p < products * span; p++)
            begin
                // stray element that breaks the sequence
                if ($urandom_range(0, 39) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_element(CMD_VECTOR, rand_value());
                    else
                        send_matrix_element(rand_value());
                    items++;
                end
                send_matrix_element(rand_value());
                items++;
            end
        end
        no_idle = 1'b0;
    endtask

    // output back-pressure
    initial
    begin
        int gap;
        forever
        begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // row result check and stall watchdog
    always @(posedge clk)
    begin : check_rows
        row_result_t want;
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_rows.size() == 0)
                    report_mismatch($sformatf("unexpected row result, row %0d sum %h",
                                              out_ch.row_number, out_ch.row_sum));
                else
                begin
                    want = pending_rows.pop_front();
                    if (out_ch.row_sum !== want.row_sum)
                        report_mismatch($sformatf("row %0d sum got %h want %h",
                                                  want.row_number, out_ch.row_sum,
                                                  want.row_sum));
                    if (out_ch.row_number !== want.row_number)
                        report_mismatch($sformatf("row number got %0d want %0d",
                                                  out_ch.row_number, want.row_number));
                    if (out_ch.last !== want.last)
                        report_mismatch($sformatf("row %0d last got %b want %b",
                                                  want.row_number, out_ch.last,
                                                  want.last));
                end
            end
        end
    end

    // reset, tests in turn, drain and verdict
    initial
    begin
        mismatches   = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        x_fill       = 0;
        col_at       = 0;
        row_at       = 0;
        row_acc      = 0;
        rows_cfg     = DIM_RESET;
        cols_cfg     = DIM_RESET;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            x_store[i]  = '0;
            x_loaded[i] = 1'b0;
        end
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_ROWS;
        cfg_data    <= '0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= CMD_VECTOR;
        in_ch.value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_dims();
        test_saturation();
        test_dim_clamp();
        test_position_rescale();
        test_random_products();

        settle_block();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
